// ===== hw/rtl/sparse_row_mask_lookup_macros.svh =====
// Assertion macros for the sparse row mask lookup block.
// Used by the top level only; needs nothing else.
`ifndef SPARSE_ROW_MASK_LOOKUP_MACROS_SVH
`define SPARSE_ROW_MASK_LOOKUP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRML_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, outside reset.
`define SRML_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srml_pkg.sv =====
// Shared types and constants of the sparse row mask lookup block.
// Used by every module of the block; depends on nothing.
package srml_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_KEY_BITS      = 32;
  localparam int DEF_VALUE_BITS    = 64;

  localparam int OP_W     = 2;
  localparam int COLUMN_W = 32;
  localparam int VALUE_W  = 64;
  localparam int SLOT_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_HIT  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Outcome of the key search for the request in the input register.
  typedef struct packed {
    logic hit;
    logic full;
  } lookup_t;

endpackage

// ===== hw/rtl/srml_table.sv =====
// Associative key/value table with a parallel key compare and in-order fill.
// Depends on srml_pkg.
module srml_table #(
  parameter int TABLE_ENTRIES = srml_pkg::DEF_TABLE_ENTRIES,
  parameter int KEY_W         = srml_pkg::DEF_KEY_BITS,
  parameter int VAL_W         = srml_pkg::DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  srml_pkg::op_t       req_op,
  input  logic [KEY_W-1:0]    req_key,
  input  logic [VAL_W-1:0]    req_value,
  output srml_pkg::lookup_t   look,
  output logic [VAL_W-1:0]    hit_value
);
  import srml_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [KEY_W-1:0]         key_r   [TABLE_ENTRIES];
  logic [VAL_W-1:0]         value_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]         fill_r;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic                     do_insert;
  logic                     do_append;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req_key);
    end
  end

  // Keys among valid entries are unique, so at most one bit of hit_vec is set
  // and an AND-OR select gives the stored value.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_value = hit_value | (value_r[i] & {VAL_W{hit_vec[i]}});
    end
  end

  assign look.hit  = |hit_vec;
  assign look.full = (fill_r == CNT_W'(TABLE_ENTRIES));

  assign do_insert = req_valid && (req_op == OP_INSERT);
  assign do_append = do_insert && !look.hit && !look.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else if (req_valid) begin
      case (req_op)
        OP_CLEAR: begin
          valid_r <= '0;
          fill_r  <= '0;
        end
        OP_INSERT: begin
          if (do_append) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (fill_r == CNT_W'(i)) begin
                valid_r[i] <= 1'b1;
              end
            end
            fill_r <= fill_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (do_insert && hit_vec[i]) begin
        value_r[i] <= req_value;
      end else if (do_append && (fill_r == CNT_W'(i))) begin
        key_r[i]   <= req_key;
        value_r[i] <= req_value;
      end
    end
  end

endmodule

// ===== hw/rtl/srml_result.sv =====
// Result formation and result register: status code, echoed slot, value.
// Depends on srml_pkg.
module srml_result #(
  parameter int VAL_W = srml_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  srml_pkg::op_t                 req_op,
  input  logic [srml_pkg::SLOT_W-1:0]   req_slot,
  input  srml_pkg::lookup_t             look,
  input  logic [VAL_W-1:0]              hit_value,
  output logic                          out_valid,
  output logic [srml_pkg::VALUE_W-1:0]  out_result_value,
  output logic [srml_pkg::SLOT_W-1:0]   out_result_slot,
  output logic [srml_pkg::STATUS_W-1:0] out_status
);
  import srml_pkg::*;

  logic                valid_r;
  logic [VALUE_W-1:0]  value_r;
  logic [VALUE_W-1:0]  value_nxt;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   slot_nxt;
  status_t             status_r;
  status_t             status_nxt;

  always_comb begin
    value_nxt  = '0;
    slot_nxt   = '0;
    status_nxt = ST_DONE;
    case (req_op)
      OP_CLEAR: begin
        status_nxt = ST_DONE;
      end
      OP_INSERT: begin
        if (!look.hit && look.full) begin
          status_nxt = ST_FULL;
        end
      end
      OP_QUERY: begin
        slot_nxt = req_slot;
        if (look.hit) begin
          value_nxt  = VALUE_W'(hit_value);
          status_nxt = ST_HIT;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = valid_r;
  assign out_result_value = value_r;
  assign out_result_slot  = slot_r;
  assign out_status       = status_r;

endmodule

// ===== hw/rtl/sparse_row_mask_lookup.sv =====
// Top level of the sparse row mask lookup block: input register, table, result.
// Depends on srml_pkg, srml_table, srml_result and the assertion macro header.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy is
//   never raised, so one request can be issued in every cycle. in_op selects
//   new row (empties the table), insert (store in_column with in_value; a
//   repeated column overwrites) or query (look up in_column, echo in_slot).
//   Each request gives exactly one result, shown for one cycle with out_valid
//   high, after it passes the input register and then the parallel key compare
//   into the result register. Throughput is one request per cycle; the single
//   compare-and-update pass over the table registers sets that figure.
//   The receiver cannot stall; a result is taken in the cycle it is shown.
//   An insert of a new column into a full table is dropped with status full.
//   Synchronous reset empties the table and discards requests in flight.
`include "sparse_row_mask_lookup_macros.svh"

module sparse_row_mask_lookup #(
  parameter int TABLE_ENTRIES = srml_pkg::DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = srml_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS    = srml_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [srml_pkg::OP_W-1:0]     in_op,
  input  logic [srml_pkg::COLUMN_W-1:0] in_column,
  input  logic [srml_pkg::VALUE_W-1:0]  in_value,
  input  logic [srml_pkg::SLOT_W-1:0]   in_slot,
  output logic                          out_valid,
  output logic [srml_pkg::VALUE_W-1:0]  out_result_value,
  output logic [srml_pkg::SLOT_W-1:0]   out_result_slot,
  output logic [srml_pkg::STATUS_W-1:0] out_status
);
  import srml_pkg::*;

  // Keys wider than the column field keep only the column bits.
  localparam int KEY_W = (KEY_BITS > COLUMN_W) ? COLUMN_W : KEY_BITS;

  logic              accept;
  logic              req_valid_r;
  op_t               req_op_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;
  logic [SLOT_W-1:0] req_slot_r;
  lookup_t           look;
  logic [VALUE_BITS-1:0] hit_value;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r    <= op_t'(in_op);
      req_key_r   <= in_column[KEY_W-1:0];
      req_value_r <= in_value[VALUE_BITS-1:0];
      req_slot_r  <= in_slot;
    end
  end

  srml_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_W         (KEY_W),
    .VAL_W         (VALUE_BITS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid_r),
    .req_op    (req_op_r),
    .req_key   (req_key_r),
    .req_value (req_value_r),
    .look      (look),
    .hit_value (hit_value)
  );

  srml_result #(
    .VAL_W (VALUE_BITS)
  ) u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req_valid_r),
    .req_op           (req_op_r),
    .req_slot         (req_slot_r),
    .look             (look),
    .hit_value        (hit_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_slot  (out_result_slot),
    .out_status       (out_status)
  );

  // Every request taken is answered by a result strobe.
  `SRML_ASSERT_NEXT(a_req_answered, clk, rst_n, accept, ##1 out_valid, "request lost")
  // A result strobe always stems from a request that was taken.
  `SRML_ASSERT_NOW(a_no_spurious, clk, rst_n, out_valid, $past(accept, 2), "spurious result")
  // Only a query hit carries stored bits.
  `SRML_ASSERT_NOW(a_value_on_hit, clk, rst_n, out_valid && (out_status != ST_HIT), out_result_value == '0, "value without hit")
  // A dropped insert is not a query, so it echoes no slot.
  `SRML_ASSERT_NOW(a_full_no_slot, clk, rst_n, out_valid && (out_status == ST_FULL), out_result_slot == '0, "slot on dropped insert")

endmodule

// ===== test/sparse_row_mask_lookup_test.sv =====
// Testbench for the sparse row mask lookup block: directed and random requests,
// with every result checked against a table model kept inside the testbench.
// Depends on srml_pkg and the sparse_row_mask_lookup top level.
`timescale 1ns / 100ps

module sparse_row_mask_lookup_test;
  import srml_pkg::*;

  localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1050;
  localparam int DRAIN_LIMIT = 200;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [VALUE_W-1:0]  result_value;
    logic [SLOT_W-1:0]   result_slot;
    logic [STATUS_W-1:0] status;
  } lookup_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_op;
  logic [COLUMN_W-1:0] in_column;
  logic [VALUE_W-1:0]  in_value;
  logic [SLOT_W-1:0]   in_slot;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_result_value;
  logic [SLOT_W-1:0]   out_result_slot;
  logic [STATUS_W-1:0] out_status;

  // Copy of the row table as the block should hold it.
  logic [COLUMN_W-1:0] row_key   [TABLE_ENTRIES];
  logic [VALUE_W-1:0]  row_value [TABLE_ENTRIES];
  bit                  row_valid [TABLE_ENTRIES];
  int                  row_fill;

  lookup_result_t pending_results[$];

  bit idle_on;
  int requests_sent;
  int results_seen;
  int error_count;
  int report_count;
  int hit_count;
  int miss_count;
  int drop_count;

  sparse_row_mask_lookup i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_column        (in_column),
    .in_value         (in_value),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_slot  (out_result_slot),
    .out_status       (out_status)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic lookup_result_t predict_lookup(input logic [OP_W-1:0] op,
                                                    input logic [COLUMN_W-1:0] column,
                                                    input logic [VALUE_W-1:0] value,
                                                    input logic [SLOT_W-1:0] slot);
    lookup_result_t res;
    int found;
    res.result_value = '0;
    res.result_slot  = '0;
    res.status       = ST_DONE;
    found = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (found < 0 && row_valid[i] && row_key[i] == column) found = i;
    end
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) row_valid[i] = 1'b0;
        row_fill = 0;
      end
      OP_INSERT: begin
        if (found >= 0) begin
          row_value[found] = value;
        end else if (row_fill < TABLE_ENTRIES) begin
          row_key[row_fill]   = column;
          row_value[row_fill] = value;
          row_valid[row_fill] = 1'b1;
          row_fill++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_QUERY: begin
        res.result_slot = slot;
        if (found >= 0) begin
          res.result_value = row_value[found];
          res.status       = ST_HIT;
        end else begin
          res.status = ST_MISS;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [COLUMN_W-1:0] random_column();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [COLUMN_W-1:0] column,
                              input logic [VALUE_W-1:0] value,
                              input logic [SLOT_W-1:0] slot);
    while (idle_on && $urandom_range(99) < 19) begin
      start = 1'b0;
      @(negedge clk);
    end
    start     = 1'b1;
    in_op     = op;
    in_column = column;
    in_value  = value;
    in_slot   = slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_lookup(op, column, value, slot));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (report_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    report_count++;
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h slot=%h status=%0d",
                                  out_result_value, out_result_slot, out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.result_value || out_result_slot !== want.result_slot ||
            out_status !== want.status) begin
          report_mismatch($sformatf(
            "expected value=%h slot=%h status=%0d, got value=%h slot=%h status=%0d",
            want.result_value, want.result_slot, want.status,
            out_result_value, out_result_slot, out_status));
        end
        case (want.status)
          ST_HIT:  hit_count++;
          ST_MISS: miss_count++;
          ST_FULL: drop_count++;
          default: ;
        endcase
      end
    end
  end

  // Empty table, extreme columns, values and slots, hits and misses.
  task automatic test_basic_lookup();
    send_request(OP_CLEAR, '1, '1, '1);
    send_request(OP_QUERY, '0, '1, '0);
    send_request(OP_INSERT, '0, '0, '1);
    send_request(OP_INSERT, '1, '1, '0);
    send_request(OP_QUERY, '1, '0, '1);
    send_request(OP_QUERY, '0, '1, 32'h1234_5678);
  endtask

  // A repeated column replaces the stored value.
  task automatic test_overwrite();
    send_request(OP_INSERT, '1, 64'h5555_aaaa_0f0f_f0f0, '0);
    send_request(OP_QUERY, '1, '0, 32'hdead_beef);
  endtask

  // The unused op code changes nothing and reports done with zero fields.
  task automatic test_unknown_op();
    send_request(OP_UNUSED, '1, '1, '1);
    send_request(OP_QUERY, '1, '0, 32'h0000_0001);
  endtask

  // Fill the table, then a new column is dropped while a known one still updates.
  task automatic test_full_table();
    logic [COLUMN_W-1:0] col;
    for (int i = 0; i < TABLE_ENTRIES - 2; i++) begin
      col = 32'h100 + i;
      send_request(OP_INSERT, col, random_value(), $urandom);
    end
    send_request(OP_INSERT, 32'h7fff_ffff, random_value(), $urandom);
    send_request(OP_INSERT, '0, 64'h8000_0000_0000_0001, $urandom);
    send_request(OP_QUERY, 32'h7fff_ffff, random_value(), 32'h8000_0000);
    send_request(OP_QUERY, '0, random_value(), 32'h7fff_ffff);
  endtask

  // Rows built from a pool of columns, then mixed inserts and queries with some noise.
  task automatic test_random_rows(input int item_count);
    logic [COLUMN_W-1:0] key_pool[$];
    int target;
    int quiet_start;
    int pool_size;
    int row_len;
    int pick;
    target      = requests_sent + item_count;
    quiet_start = requests_sent + item_count / 2;
    while (requests_sent < target) begin
      idle_on = !(requests_sent >= quiet_start && requests_sent < quiet_start + 150);
      send_request(OP_CLEAR, random_column(), random_value(), $urandom);
      key_pool.delete();
      pool_size = ($urandom_range(4) == 0) ? $urandom_range(TABLE_ENTRIES + 1, TABLE_ENTRIES + 8)
                                           : $urandom_range(1, 12);
      for (int i = 0; i < pool_size; i++) key_pool.push_back(random_column());
      foreach (key_pool[i]) send_request(OP_INSERT, key_pool[i], random_value(), $urandom);
      row_len = $urandom_range(4, 40);
      repeat (row_len) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          send_request(OP_INSERT, key_pool[$urandom_range(pool_size - 1)], random_value(),
                       $urandom);
        end else if (pick < 80) begin
          send_request(OP_QUERY, key_pool[$urandom_range(pool_size - 1)], random_value(),
                       $urandom);
        end else if (pick < 90) begin
          send_request(OP_QUERY, random_column(), random_value(), $urandom);
        end else if (pick < 95) begin
          send_request(OP_UNUSED, random_column(), random_value(), $urandom);
        end else if (pick < 98) begin
          send_request(OP_INSERT, random_column(), random_value(), $urandom);
        end else begin
          send_request(OP_CLEAR, random_column(), random_value(), $urandom);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int waited;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_op     = OP_CLEAR;
    in_column = '0;
    in_value  = '0;
    in_slot   = '0;
    idle_on   = 1'b1;
    requests_sent = 0;
    results_seen  = 0;
    error_count   = 0;
    report_count  = 0;
    hit_count     = 0;
    miss_count    = 0;
    drop_count    = 0;
    row_fill      = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      row_valid[i] = 1'b0;
      row_key[i]   = '0;
      row_value[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_lookup();
    test_overwrite();
    test_unknown_op();
    test_full_table();
    test_random_rows(RANDOM_REQUESTS);

    start = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
    if (pending_results.size() != 0) begin
      error_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("Sent %0d requests and checked %0d results, %0d errors.",
             requests_sent, results_seen, error_count);
    $display("Queries: %0d hits, %0d misses; inserts dropped on a full table: %0d.",
             hit_count, miss_count, drop_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Timeout: the run did not finish in time.");
    $display("Some tests failed");
    $finish;
  end

endmodule
